// ===== design/wbh_pkg.sv =====
// ----------------------------------------------------------------------------
// wbh_pkg: shared types and helpers for the word bucket hash
// Character codes, the word-length limit, the end-of-word snapshot type and
// the class rule on the first two characters used for the second digit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbh_pkg;

  localparam int MAX_WORD = 45;

  localparam logic [7:0] LC_A = 8'h61;
  localparam logic [7:0] LC_Z = 8'h7a;
  localparam logic [7:0] APOS = 8'h27;

  // Everything the result stage needs once a word has ended.
  typedef struct packed {
    logic [5:0]        count;
    logic [5:0][7:0]   lead;
    logic [3:0]        sum;
    logic signed [15:0] acc;
    logic              bad;
  } snap_t;

  function automatic logic [3:0] digit_two(input logic [7:0] c0, input logic [7:0] c1);
    logic [3:0] d;
    if ((c0 == 8'h74 && c0 > c1) || c0 == 8'h6d) d = 4'd0;
    else if ((c0 == 8'h74 && c1 >= c0) || c0 == 8'h70 || (c0 == 8'h6f && c0 > c1)) d = 4'd1;
    else if (c0 == 8'h73 || c0 == 8'h79) d = 4'd2;
    else if (c0 == 8'h61 || c0 == 8'h77) d = 4'd3;
    else if (c0 == 8'h63 || c0 == 8'h65) d = 4'd4;
    else if ((c0 == 8'h6f && c1 >= c0) || c0 == 8'h6c || c0 == 8'h67) d = 4'd5;
    else if (c0 == 8'h72 || c0 == 8'h69) d = 4'd6;
    else if (c0 == 8'h68 || c0 == 8'h75 || c0 == 8'h6e) d = 4'd7;
    else if (c0 == 8'h62 || c0 == 8'h66) d = 4'd8;
    else d = 4'd9;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/wbh_if.sv =====
// ----------------------------------------------------------------------------
// wbh_if: character and result channel interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source(output valid, ch, last, input ready);
  modport sink(input valid, ch, last, output ready);
endinterface

interface wbh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bucket;
  logic        bad_word;
  modport source(output valid, bucket, bad_word, input ready);
  modport sink(input valid, bucket, bad_word, output ready);
endinterface

`default_nettype wire

// ===== design/word_bucket_hash.sv =====
// The final character's beat passes the input, snapshot and result registers before the result beat is valid.
// Throughput: one character beat per cycle, set by the state update in the accumulate
//   stage, while results are taken; a word's result follows at the same rate.
// A one-entry snapshot register lets characters keep flowing while a result waits.
// Reset (rst_n low, synchronous) empties all stages and clears the word state.
// ----------------------------------------------------------------------------
// word_bucket_hash: streaming word to bucket index hash
// Characters enter one per beat; each word ending in a last beat yields one
// bucket index and a bad-word flag.
// ----------------------------------------------------------------------------
`default_nettype none

module word_bucket_hash (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wbh_in_if.sink     in_chan,
  wbh_out_if.source  out_chan
);
  import wbh_pkg::*;

  snap_t snap;
  logic  snap_valid;
  logic  snap_ready;

  wbh_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  wbh_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

// ===== design/wbh_accum.sv =====
// ----------------------------------------------------------------------------
// wbh_accum: per-character word state update
// Registers each character beat, folds it into the running word state and,
// on the final character, hands a snapshot of the word to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wbh_accum (
  input  wire logic         clk,
  input  wire logic         rst_n,
  wbh_in_if.sink            in_chan,
  output wbh_pkg::snap_t    snap,
  output logic              snap_valid,
  input  wire logic         snap_ready
);
  import wbh_pkg::*;

  logic               in_v_r;
  logic [7:0]         in_ch_r;
  logic               in_last_r;

  logic [5:0]         count_r,  count_nxt;
  logic [5:0][7:0]    lead_r,   lead_nxt;
  logic [3:0]         sum_r,    sum_nxt;
  logic signed [15:0] acc_r,    acc_nxt;
  logic               bad_r,    bad_nxt;
  logic               snap_v_r;
  snap_t              snap_r,   snap_nxt;

  logic               letter, legal, bad_now, upd;
  logic signed [8:0]  v;
  logic signed [17:0] prod;
  logic [7:0]         diff;
  logic [5:0]         tsum;
  logic               snap_free, proc, in_rdy;
  snap_t              word_upd;

  assign snap_free = !snap_v_r || snap_ready;
  assign proc      = in_v_r && (!in_last_r || snap_free);
  assign in_rdy    = !in_v_r || proc;
  assign in_chan.ready = in_rdy;
  assign snap       = snap_r;
  assign snap_valid = snap_v_r;

  always_comb begin
    letter  = (in_ch_r >= LC_A) && (in_ch_r <= LC_Z);
    legal   = letter || (in_ch_r == APOS);
    bad_now = !legal || (count_r >= 6'(MAX_WORD));
    upd     = !bad_now && !bad_r;
    // An apostrophe maps to -57, letters to 1..26.
    v       = $signed({1'b0, in_ch_r}) - 9'sd96;
    prod    = $signed(acc_r[8:0]) * v;
    diff    = in_ch_r - LC_A;
    tsum    = {2'b00, sum_r} + diff[5:0];

    word_upd.count = (count_r == 6'd63) ? count_r : count_r + 6'd1;
    word_upd.lead  = lead_r;
    word_upd.sum   = sum_r;
    word_upd.acc   = acc_r;
    word_upd.bad   = bad_r || bad_now;

    if (upd) begin
      if (count_r < 6'd6) begin
        word_upd.lead[count_r[2:0]] = in_ch_r;
      end
      if (count_r == 6'd0) begin
        word_upd.acc = {{7{v[8]}}, v};
      end else if (count_r == 6'd1) begin
        word_upd.acc = prod[15:0];
      end else begin
        word_upd.acc = acc_r - {{7{v[8]}}, v};
      end
      if (letter) begin
        if (tsum >= 6'd30)      word_upd.sum = 4'(tsum - 6'd30);
        else if (tsum >= 6'd20) word_upd.sum = 4'(tsum - 6'd20);
        else if (tsum >= 6'd10) word_upd.sum = 4'(tsum - 6'd10);
        else                    word_upd.sum = tsum[3:0];
      end
    end

    count_nxt = count_r;
    lead_nxt  = lead_r;
    sum_nxt   = sum_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    snap_nxt  = snap_r;
    if (proc) begin
      if (in_last_r) begin
        // The word ends here: hand it over and start the next one clean.
        snap_nxt  = word_upd;
        count_nxt = '0;
        lead_nxt  = '0;
        sum_nxt   = '0;
        acc_nxt   = '0;
        bad_nxt   = 1'b0;
      end else begin
        count_nxt = word_upd.count;
        lead_nxt  = word_upd.lead;
        sum_nxt   = word_upd.sum;
        acc_nxt   = word_upd.acc;
        bad_nxt   = word_upd.bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      snap_v_r <= 1'b0;
      count_r  <= '0;
      lead_r   <= '0;
      sum_r    <= '0;
      acc_r    <= '0;
      bad_r    <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_v_r <= in_chan.valid;
      end
      if (proc && in_last_r) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
      count_r <= count_nxt;
      lead_r  <= lead_nxt;
      sum_r   <= sum_nxt;
      acc_r   <= acc_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_chan.valid) begin
      in_ch_r   <= in_chan.ch;
      in_last_r <= in_chan.last;
    end
    snap_r <= snap_nxt;
  end

endmodule

`default_nettype wire

// ===== design/wbh_finish.sv =====
// ----------------------------------------------------------------------------
// wbh_finish: bucket index assembly and result register
// Turns a finished word snapshot into the five-digit bucket and holds it in
// the output register until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wbh_finish (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire wbh_pkg::snap_t snap,
  input  wire logic         snap_valid,
  output logic              snap_ready,
  wbh_out_if.source         out_chan
);
  import wbh_pkg::*;

  logic        out_v_r;
  logic [15:0] bucket_r, bucket_nxt;
  logic        bad_r;
  logic        load;

  logic [15:0] mag16;
  logic [13:0] mag;
  logic [26:0] qprod;
  logic [10:0] quo;
  logic [13:0] rem;
  logic [1:0]  d1;
  logic [3:0]  d2, d3, d5;
  logic [2:0]  cat;
  logic [7:0]  c1;

  assign snap_ready = !out_v_r || out_chan.ready;
  assign load       = snap_valid && snap_ready;

  assign out_chan.valid    = out_v_r;
  assign out_chan.bucket   = bucket_r;
  assign out_chan.bad_word = bad_r;

  always_comb begin
    mag16 = snap.acc[15] ? 16'(-snap.acc) : 16'(snap.acc);
    // The accumulator stays well inside 14 bits of magnitude, where the
    // reciprocal 6554/65536 gives an exact quotient by ten.
    mag   = mag16[13:0];
    qprod = 27'(mag) * 27'd6554;
    quo   = qprod[26:16];
    rem   = mag - 14'({quo, 3'b000} + {2'b00, quo, 1'b0});
    d3    = rem[3:0];

    if (snap.count < 6'd9 || snap.count == 6'd13) d1 = {1'b0, snap.count[0]};
    else                                          d1 = {1'b1, snap.count[0]};

    c1 = (snap.count >= 6'd2) ? snap.lead[1] : 8'h00;
    d2 = digit_two(snap.lead[0], c1);

    if (snap.count < 6'd4)                   cat = 3'd1;
    else if (snap.lead[1] > snap.lead[2])    cat = snap.lead[3][0] ? 3'd2 : 3'd1;
    else if (!snap.lead[3][0])               cat = 3'd3;
    else if (snap.count > 6'd5 && snap.lead[4] > snap.lead[5]) cat = 3'd4;
    else                                     cat = 3'd5;
    d5 = 4'(cat - 3'd1) + (mag[1] ? 4'd5 : 4'd0);

    bucket_nxt = 16'(d1) * 16'd10000 + 16'(d2) * 16'd1000 + 16'(d3) * 16'd100
               + 16'(snap.sum) * 16'd10 + 16'(d5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bucket_r <= snap.bad ? 16'd0 : bucket_nxt;
      bad_r    <= snap.bad;
    end
  end

endmodule

`default_nettype wire

// ===== design/wbh_checker.sv =====
// ----------------------------------------------------------------------------
// wbh_checker: port-level checks for the word bucket hash
// Watches the result channel for stall, range, bad-word and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module wbh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_bucket,
  input wire logic        out_bad_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bucket) && $stable(out_bad_word))
    else $error("result beat changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_word |-> out_bucket == 16'd0)
    else $error("bad word with nonzero bucket");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bucket <= 16'd39999)
    else $error("bucket out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind word_bucket_hash wbh_checker u_wbh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_bucket   (out_chan.bucket),
  .out_bad_word (out_chan.bad_word)
);

`default_nettype wire
